/* rtl/core/clhp_pkg.sv */
package clhp_pkg;

	// characters in the matched header name, colon included
	localparam int NAME_LEN = 15;
	localparam int NAME_IDX_W = 4;
	localparam int LEN_W = 64;

	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0b;
	localparam logic [7:0] CH_FF    = 8'h0c;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5a;

	localparam logic [1:0] STATUS_FOUND     = 2'd0;
	localparam logic [1:0] STATUS_ABSENT    = 2'd1;
	localparam logic [1:0] STATUS_MALFORMED = 2'd2;

	typedef enum logic [2:0] {
		PH_NAME   = 3'd0,
		PH_GAP    = 3'd1,
		PH_LEAD   = 3'd2,
		PH_SIGN   = 3'd3,
		PH_DIGITS = 3'd4,
		PH_STOP   = 3'd5,
		PH_SKIP   = 3'd6
	} phase_t;

	typedef struct packed {
		logic [1:0]              status;
		logic signed [LEN_W-1:0] length_value;
	} result_t;

	// lower-case header name, one character per index
	function automatic logic [7:0] name_char(input logic [NAME_IDX_W-1:0] idx);
		logic [7:0] ch;
		case (idx)
			4'd0:    ch = 8'h63; // c
			4'd1:    ch = 8'h6f; // o
			4'd2:    ch = 8'h6e; // n
			4'd3:    ch = 8'h74; // t
			4'd4:    ch = 8'h65; // e
			4'd5:    ch = 8'h6e; // n
			4'd6:    ch = 8'h74; // t
			4'd7:    ch = 8'h2d; // -
			4'd8:    ch = 8'h6c; // l
			4'd9:    ch = 8'h65; // e
			4'd10:   ch = 8'h6e; // n
			4'd11:   ch = 8'h67; // g
			4'd12:   ch = 8'h74; // t
			4'd13:   ch = 8'h68; // h
			4'd14:   ch = 8'h3a; // :
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

/* rtl/core/clhp_byte_if.sv */
interface clhp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] header_byte;
	logic       region_end;

	modport source (output valid, output header_byte, output region_end, input ready);
	modport sink   (input valid, input header_byte, input region_end, output ready);
endinterface

/* rtl/core/clhp_result_if.sv */
interface clhp_result_if;
	logic                                valid;
	logic                                ready;
	logic [1:0]                          status;
	logic signed [clhp_pkg::LEN_W-1:0]   length_value;

	modport source (output valid, output status, output length_value, input ready);
	modport sink   (input valid, input status, input length_value, output ready);
endinterface

/* rtl/core/clhp_out_queue.sv */
module clhp_out_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  clhp_pkg::result_t push_data,
	output logic              space,
	clhp_result_if.source     result
);
	import clhp_pkg::*;

	result_t head_q;
	result_t skid_q;
	logic    head_v_q;
	logic    skid_v_q;
	logic    pop;

	// a push is only offered while the skid slot is free
	assign space = !skid_v_q;
	assign pop   = head_v_q && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				head_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end
		end else if (head_v_q && !pop) begin
			if (push) begin
				skid_v_q <= 1'b1;
			end
		end else begin
			head_v_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				head_q <= skid_q;
			end
		end else if (head_v_q && !pop) begin
			if (push) begin
				skid_q <= push_data;
			end
		end else if (push) begin
			head_q <= push_data;
		end
	end

	assign result.valid        = head_v_q;
	assign result.status       = head_q.status;
	assign result.length_value = head_q.length_value;

endmodule

/* rtl/core/content_length_header_parser.sv */
// Content-Length header parser. Header bytes enter on the header channel one item per
// byte, with region_end set on the last byte of a header region; lines end in CR LF. The
// first line that begins with "Content-Length:" (any letter case) is read: spaces and tabs
// after the colon are skipped, then up to FIELD_CHARS characters are parsed as a signed
// decimal number in the manner of strtol, saturating at the VALUE_BITS extremes and
// sign-extended to 64 bits. Exactly one result item leaves per region: status found with
// the value on the LF that closes that line, status malformed (value -1) when no digit
// followed the name, or status absent (value -1) on the region_end byte when no complete
// matching line was seen. An unfinished last line is dropped. The block takes one byte
// per cycle while the result queue has space; a byte is held in the input register, and
// its result is written into the result queue, from which it leaves. The per-byte state
// update (name compare and a times-ten accumulate with overflow compare) is combinational.
// Input stalls only when two results are already waiting in the two-entry result queue.
module content_length_header_parser #(
	parameter int FIELD_CHARS = 63,
	parameter int VALUE_BITS  = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	clhp_byte_if.sink     header,
	clhp_result_if.source result
);
	import clhp_pkg::*;

	localparam int CNT_W  = $clog2(FIELD_CHARS + 1);
	localparam int WIDE_W = VALUE_BITS + 4;

	// input register
	logic [7:0] byte_s1;
	logic       end_s1;
	logic       vld_s1;

	// parse state
	phase_t                  phase_q;
	logic [NAME_IDX_W-1:0]   idx_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    pcr_q;
	logic                    neg_q;
	logic [VALUE_BITS-1:0]   mag_q;
	logic                    sat_q;
	logic                    dig_q;
	logic                    answered_q;

	phase_t                  phase_n;
	logic [NAME_IDX_W-1:0]   idx_n;
	logic [CNT_W-1:0]        cnt_n;
	logic                    pcr_n;
	logic                    neg_n;
	logic [VALUE_BITS-1:0]   mag_n;
	logic                    sat_n;
	logic                    dig_n;
	logic                    answered_n;

	logic    res_v;
	result_t res_d;
	logic    q_space;
	logic    s1_go;

	// times-ten accumulate, straight from the registers: digits never share a byte with
	// a sign change or with a second digit
	logic [VALUE_BITS-1:0] half;
	logic [WIDE_W-1:0]     limit_w;
	logic [WIDE_W-1:0]     mag_w;
	logic [WIDE_W-1:0]     acc_w;
	logic                  acc_over;

	assign half     = {1'b1, {(VALUE_BITS-1){1'b0}}};
	assign limit_w  = WIDE_W'(neg_q ? half : half - 1'b1);
	assign mag_w    = WIDE_W'(mag_q);
	assign acc_w    = (mag_w << 3) + (mag_w << 1) + WIDE_W'(byte_s1[3:0]);
	assign acc_over = acc_w > limit_w;

	// the byte advances when the result queue can take whatever it may produce
	assign s1_go        = vld_s1 && q_space;
	assign header.ready = !vld_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (header.ready) begin
			vld_s1 <= header.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (header.ready && header.valid) begin
			byte_s1 <= header.header_byte;
			end_s1  <= header.region_end;
		end
	end

	always_comb begin
		logic [7:0]         c;
		logic [7:0]         lc;
		logic               is_dig;
		logic               is_ws;
		logic               line_done;
		logic               do_content;
		logic               room;
		logic signed [VALUE_BITS-1:0] sval;

		c      = byte_s1;
		lc     = (c >= CH_UP_A && c <= CH_UP_Z) ? c + 8'h20 : c;
		is_dig = c >= CH_ZERO && c <= CH_NINE;
		is_ws  = c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
			c == CH_FF || c == CH_CR;

		phase_n    = phase_q;
		idx_n      = idx_q;
		cnt_n      = cnt_q;
		pcr_n      = pcr_q;
		neg_n      = neg_q;
		mag_n      = mag_q;
		sat_n      = sat_q;
		dig_n      = dig_q;
		answered_n = answered_q;
		res_v      = 1'b0;
		res_d      = '{status: STATUS_ABSENT, length_value: '1};
		line_done  = 1'b0;
		do_content = 1'b0;
		room       = 1'b0;
		sval       = '0;

		if (!answered_q) begin
			if (pcr_q) begin
				if (c == CH_LF) begin
					pcr_n     = 1'b0;
					line_done = 1'b1;
				end else begin
					// held CR turns out to be an ordinary character
					room = cnt_q < CNT_W'(FIELD_CHARS);
					case (phase_q)
						PH_NAME: begin
							phase_n = PH_SKIP;
						end
						PH_GAP, PH_LEAD, PH_STOP: begin
							if (phase_q == PH_GAP) begin
								phase_n = PH_LEAD;
							end
							if (room) begin
								cnt_n = CNT_W'(cnt_q + 1'b1);
							end
						end
						PH_SIGN, PH_DIGITS: begin
							if (room) begin
								cnt_n   = CNT_W'(cnt_q + 1'b1);
								phase_n = PH_STOP;
							end
						end
						default: begin
						end
					endcase
					if (c != CH_CR) begin
						pcr_n      = 1'b0;
						do_content = 1'b1;
					end
				end
			end else if (c == CH_CR) begin
				pcr_n = 1'b1;
			end else begin
				do_content = 1'b1;
			end

			if (do_content) begin
				if (phase_n == PH_NAME) begin
					if (idx_n < NAME_IDX_W'(NAME_LEN) && lc == name_char(idx_n)) begin
						if (idx_n == NAME_IDX_W'(NAME_LEN - 1)) begin
							phase_n = PH_GAP;
						end
						idx_n = NAME_IDX_W'(idx_n + 1'b1);
					end else begin
						phase_n = PH_SKIP;
					end
				end else begin
					if (phase_n == PH_GAP && c != CH_SPACE && c != CH_TAB) begin
						phase_n = PH_LEAD;
					end
					room = cnt_n < CNT_W'(FIELD_CHARS);
					if (room && (phase_n == PH_LEAD || phase_n == PH_SIGN ||
						phase_n == PH_DIGITS || phase_n == PH_STOP)) begin
						cnt_n = CNT_W'(cnt_n + 1'b1);
						if (phase_n == PH_LEAD && is_ws) begin
							// leading white space
						end else if (phase_n == PH_LEAD && c == CH_PLUS) begin
							phase_n = PH_SIGN;
						end else if (phase_n == PH_LEAD && c == CH_MINUS) begin
							neg_n   = 1'b1;
							phase_n = PH_SIGN;
						end else if (phase_n != PH_STOP) begin
							if (is_dig) begin
								dig_n   = 1'b1;
								phase_n = PH_DIGITS;
								if (!sat_q) begin
									if (acc_over) begin
										sat_n = 1'b1;
										mag_n = limit_w[VALUE_BITS-1:0];
									end else begin
										mag_n = acc_w[VALUE_BITS-1:0];
									end
								end
							end else begin
								phase_n = PH_STOP;
							end
						end
					end
				end
			end

			if (line_done) begin
				if (phase_q == PH_GAP || phase_q == PH_LEAD || phase_q == PH_SIGN ||
					phase_q == PH_DIGITS || phase_q == PH_STOP) begin
					res_v      = 1'b1;
					answered_n = 1'b1;
					if (dig_q) begin
						sval               = $signed(neg_q ? -mag_q : mag_q);
						res_d.status       = STATUS_FOUND;
						res_d.length_value = LEN_W'(sval);
					end else begin
						res_d.status = STATUS_MALFORMED;
					end
				end else begin
					// line finished without a match: start the next one
					phase_n = PH_NAME;
					idx_n   = '0;
					cnt_n   = '0;
					neg_n   = 1'b0;
					mag_n   = '0;
					sat_n   = 1'b0;
					dig_n   = 1'b0;
				end
			end
		end

		if (end_s1) begin
			if (!answered_n) begin
				res_v = 1'b1;
				res_d = '{status: STATUS_ABSENT, length_value: '1};
			end
			// back to reset for the next region
			phase_n    = PH_NAME;
			idx_n      = '0;
			cnt_n      = '0;
			pcr_n      = 1'b0;
			neg_n      = 1'b0;
			mag_n      = '0;
			sat_n      = 1'b0;
			dig_n      = 1'b0;
			answered_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_NAME;
			idx_q      <= '0;
			cnt_q      <= '0;
			pcr_q      <= 1'b0;
			neg_q      <= 1'b0;
			mag_q      <= '0;
			sat_q      <= 1'b0;
			dig_q      <= 1'b0;
			answered_q <= 1'b0;
		end else if (s1_go) begin
			phase_q    <= phase_n;
			idx_q      <= idx_n;
			cnt_q      <= cnt_n;
			pcr_q      <= pcr_n;
			neg_q      <= neg_n;
			mag_q      <= mag_n;
			sat_q      <= sat_n;
			dig_q      <= dig_n;
			answered_q <= answered_n;
		end
	end

	// result register plus one skid slot
	clhp_out_queue u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s1_go && res_v),
		.push_data (res_d),
		.space     (q_space),
		.result    (result)
	);

endmodule
